// ===== hw/rtl/adsr_gate_pkg.sv =====
`default_nettype none

package adsr_gate_pkg;

  // Envelope phase codes, as reported on the result channel
  localparam int PHASE_W = 3;
  typedef logic [PHASE_W-1:0] phase_t;

  localparam phase_t PH_OFF     = 3'd0;
  localparam phase_t PH_ATTACK  = 3'd1;
  localparam phase_t PH_DECAY   = 3'd2;
  localparam phase_t PH_SUSTAIN = 3'd3;
  localparam phase_t PH_RELEASE = 3'd4;

  // Configuration channel layout
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_THRESHOLD = 3'd0;
  localparam cfg_idx_t REG_ATTACK    = 3'd1;
  localparam cfg_idx_t REG_DECAY     = 3'd2;
  localparam cfg_idx_t REG_RELEASE   = 3'd3;
  localparam cfg_idx_t REG_SUSTAIN   = 3'd4;

  // Sustain gain after reset (one half at 16 fraction bits)
  localparam int SUSTAIN_RESET = 32768;

endpackage

`default_nettype wire

// ===== hw/rtl/adsr_gate_if.sv =====
`default_nettype none

// Sample channel: audio sample, trigger sample, retrigger flag
interface adsr_gate_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic signed [SAMPLE_WIDTH-1:0] trigger_level;
  logic                           retrigger;

  modport source (output valid, sample_in, trigger_level, retrigger, input ready);
  modport sink   (input valid, sample_in, trigger_level, retrigger, output ready);
endinterface

// Result channel: shaped sample and phase reached
interface adsr_gate_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  adsr_gate_pkg::phase_t          phase;

  modport source (output valid, sample_out, phase, input ready);
  modport sink   (input valid, sample_out, phase, output ready);
endinterface

// Register write channel
interface adsr_gate_cfg_if;
  logic                                      valid;
  logic                                      ready;
  adsr_gate_pkg::cfg_idx_t                   index;
  logic [adsr_gate_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/adsr_envelope_gate_unit.sv =====
`default_nettype none

// Channel   Role     Payload
// -------   ------   ------------------------------------------------
// in_ch     sink     sample_in, trigger_level, retrigger
// out_ch    source   sample_out, phase
// cfg_ch    sink     index, data (register writes, always ready)
//
// A sample that needs a ramp division keeps in_ch busy while the restoring
// divider, one quotient bit per cycle, works; other samples go straight to
// the final scaling. A single multiplier serves the decay slope, the release
// scaling and the final sample scaling.
// rst is synchronous; it clears phase, counters, gain and the configuration registers, with sustain reset to one half.
// A finished result waits in the output register; in_ch is taken again
// meanwhile, and only the next result stalls until out_ch drains.

module adsr_envelope_gate_unit #(
  parameter int COUNT_WIDTH    = 24,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  adsr_gate_in_if.sink     in_ch,
  adsr_gate_cfg_if.sink    cfg_ch,
  adsr_gate_out_if.source  out_ch
);
  import adsr_gate_pkg::*;

  localparam int CW  = COUNT_WIDTH;
  localparam int SW  = SAMPLE_WIDTH;
  localparam int F   = GAIN_FRAC_BITS;
  localparam int GW  = F + 1;
  localparam int NW  = CW + F;
  localparam int MA0 = (CW > SW) ? CW : SW;
  localparam int MA  = ((MA0 > GW) ? MA0 : GW) + 1;
  localparam int PW  = MA + GW + 1;
  localparam int IW  = $clog2(F + 1);

  localparam logic [GW-1:0] UNITY = {1'b1, {F{1'b0}}};

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_STEP  = 4'd1;
  localparam logic [3:0] S_DMUL  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_DEND  = 4'd4;
  localparam logic [3:0] S_RMUL  = 4'd5;
  localparam logic [3:0] S_RENV  = 4'd6;
  localparam logic [3:0] S_SCALE = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]            state;
  phase_t                phase;
  logic [CW:0]           acnt, dcnt, rcnt;
  logic [GW-1:0]         gain, env;
  logic signed [SW-1:0]  xs;
  logic                  gate;

  // Configuration registers
  logic signed [SW-1:0]  thr;
  logic [CW-1:0]         alen, dlen, rlen;
  logic [GW-1:0]         sus;

  // Divider and multiplier registers
  logic [CW-1:0]         rem;
  logic [GW-1:0]         qn;
  logic [CW-1:0]         dvs;
  logic [IW-1:0]         iter;
  logic signed [PW-1:0]  prod;

  // Output register
  logic                  out_valid;
  logic signed [SW-1:0]  out_sample;
  phase_t                out_phase;

  logic [GW-1:0]         s_eff, k_slope, f_rel;
  logic [CW:0]           cnt_cur, c_inc;
  logic [CW-1:0]         len_cur;
  logic                  ph_end;
  logic [CW:0]           r2, r2sub;
  logic                  ge;
  logic [CW-1:0]         rem_next;
  logic [NW-1:0]         n_load;
  logic signed [MA-1:0]  mul_a;
  logic [GW-1:0]         mul_b;
  logic signed [PW-1:0]  ma_ext, mb_ext, mul_p;

  assign in_ch.ready   = (state == S_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;
  assign out_ch.phase      = out_phase;

  // Sustain clamped to unity, and the decay drop
  assign s_eff   = (sus[F] && (|sus[F-1:0])) ? UNITY : sus;
  assign k_slope = UNITY - s_eff;
  assign f_rel   = UNITY - qn;

  // Counter and length of the phase in progress
  always_comb begin
    case (phase)
      PH_ATTACK: begin
        cnt_cur = acnt;
        len_cur = alen;
      end
      PH_DECAY: begin
        cnt_cur = dcnt;
        len_cur = dlen;
      end
      PH_RELEASE: begin
        cnt_cur = rcnt;
        len_cur = rlen;
      end
      default: begin
        cnt_cur = '0;
        len_cur = '0;
      end
    endcase
  end

  assign c_inc  = cnt_cur + 1'b1;
  assign ph_end = (c_inc > {1'b0, len_cur}) || (len_cur == '0);

  // Restoring divider step: one quotient bit per cycle
  assign r2       = {rem, qn[GW-1]};
  assign ge       = (r2 >= {1'b0, dvs});
  assign r2sub    = r2 - {1'b0, dvs};
  assign rem_next = ge ? r2sub[CW-1:0] : r2[CW-1:0];

  // Shared multiplier operands
  always_comb begin
    unique case (state)
      S_DMUL: begin
        mul_a = {{(MA-CW){1'b0}}, dcnt[CW-1:0]};
        mul_b = k_slope;
      end
      S_RMUL: begin
        mul_a = {{(MA-GW){1'b0}}, f_rel};
        mul_b = gain;
      end
      S_SCALE: begin
        mul_a = {{(MA-SW){xs[SW-1]}}, xs};
        mul_b = env;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign ma_ext = {{(PW-MA){mul_a[MA-1]}}, mul_a};
  assign mb_ext = {{(PW-GW){1'b0}}, mul_b};
  assign mul_p  = ma_ext * mb_ext;

  // Dividend: decay slope product, else count shifted to gain scale
  assign n_load = (state == S_DMUL) ? mul_p[NW-1:0] : {c_inc[CW-1:0], {F{1'b0}}};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thr  <= '0;
      alen <= '0;
      dlen <= '0;
      rlen <= '0;
      sus  <= GW'(SUSTAIN_RESET);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_THRESHOLD: thr  <= cfg_ch.data[SW-1:0];
        REG_ATTACK:    alen <= cfg_ch.data[CW-1:0];
        REG_DECAY:     dlen <= cfg_ch.data[CW-1:0];
        REG_RELEASE:   rlen <= cfg_ch.data[CW-1:0];
        REG_SUSTAIN:   sus  <= cfg_ch.data[GW-1:0];
        default: ;
      endcase
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid) begin
      xs <= in_ch.sample_in;
    end
    if (state == S_STEP) begin
      dvs <= len_cur;
    end
    if ((state == S_STEP) || (state == S_DMUL)) begin
      rem  <= {1'b0, n_load[NW-1:GW]};
      qn   <= n_load[GW-1:0];
      iter <= IW'(F);
    end else if (state == S_DIV) begin
      rem <= rem_next;
      qn  <= {qn[GW-2:0], ge};
      if (iter != '0) begin
        iter <= iter - 1'b1;
      end
    end
    if ((state == S_RMUL) || (state == S_SCALE)) begin
      prod <= mul_p;
    end
  end

  // Sequencer and envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_OFF;
      acnt      <= '0;
      dcnt      <= '0;
      rcnt      <= '0;
      gain      <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drained result; S_OUT decides on its own when it refills
      if (out_valid && out_ch.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            gate <= (in_ch.trigger_level >= thr);
            if (in_ch.retrigger) begin
              phase <= PH_ATTACK;
              acnt  <= '0;
            end
            state <= S_STEP;
          end
        end

        S_STEP: begin
          unique case (phase)
            PH_ATTACK: begin
              acnt <= c_inc;
              if (ph_end) begin
                phase <= PH_DECAY;
                dcnt  <= '0;
                gain  <= UNITY;
                env   <= UNITY;
                state <= S_SCALE;
              end else begin
                state <= S_DIV;
              end
            end
            PH_DECAY: begin
              dcnt <= c_inc;
              if (ph_end) begin
                phase <= PH_SUSTAIN;
                gain  <= s_eff;
                env   <= s_eff;
                state <= S_SCALE;
              end else begin
                state <= S_DMUL;
              end
            end
            PH_SUSTAIN: begin
              env <= s_eff;
              if (!gate) begin
                phase <= PH_RELEASE;
                rcnt  <= '0;
              end
              state <= S_SCALE;
            end
            PH_RELEASE: begin
              rcnt <= c_inc;
              if (ph_end) begin
                gain  <= '0;
                phase <= PH_OFF;
                env   <= '0;
                state <= S_SCALE;
              end else if (gate) begin
                phase <= PH_ATTACK;
                acnt  <= '0;
                env   <= '0;
                state <= S_SCALE;
              end else begin
                state <= S_DIV;
              end
            end
            default: begin
              // off, and unused codes treated as off
              env <= '0;
              if (gate) begin
                phase <= PH_ATTACK;
                acnt  <= '0;
              end else begin
                phase <= PH_OFF;
              end
              state <= S_SCALE;
            end
          endcase
        end

        S_DMUL: begin
          state <= S_DIV;
        end

        S_DIV: begin
          if (iter == '0) begin
            state <= S_DEND;
          end
        end

        // Quotient ready in qn
        S_DEND: begin
          unique case (phase)
            PH_ATTACK: begin
              gain <= qn;
              env  <= qn;
              if (!gate) begin
                phase <= PH_RELEASE;
                rcnt  <= '0;
              end
              state <= S_SCALE;
            end
            PH_DECAY: begin
              gain <= UNITY - qn;
              env  <= UNITY - qn;
              if (!gate) begin
                phase <= PH_RELEASE;
                rcnt  <= '0;
              end
              state <= S_SCALE;
            end
            default: begin
              state <= S_RMUL;
            end
          endcase
        end

        S_RMUL: begin
          state <= S_RENV;
        end

        S_RENV: begin
          env   <= prod[GW+F-1:F];
          state <= S_SCALE;
        end

        S_SCALE: begin
          state <= S_OUT;
        end

        // Floor of the scaled sample is an arithmetic shift
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_sample <= prod[F+SW-1:F];
            out_phase  <= phase;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/adsr_gate_chk.sv =====
`default_nettype none

module adsr_gate_chk #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] out_sample,
  input adsr_gate_pkg::phase_t          out_phase
);
  import adsr_gate_pkg::*;

  // After an accepted item the input side stays busy while the sequencer works on it
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken again too soon after a transaction");

  // The off phase carries no gain, so the sample is silent
  a_off_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_phase == PH_OFF) |-> out_sample == '0)
    else $error("nonzero sample in off phase");

  // A new result only appears after the sequencer was busy
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a busy cycle");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_phase))
    else $error("stalled result changed");

endmodule

bind adsr_envelope_gate_unit adsr_gate_chk #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample_out),
  .out_phase  (out_ch.phase)
);

`default_nettype wire

// ===== test/tb_adsr_envelope_gate_unit.sv =====
`default_nettype none

module tb_adsr_envelope_gate_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import adsr_gate_pkg::*;

  localparam int     FRAC_BITS    = 16;
  localparam longint UNITY        = longint'(1) << FRAC_BITS;
  localparam int     IDLE_MAX     = 6;
  localparam int     STALL_LIMIT  = 1000;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     TOTAL_ITEMS  = 1050;
  localparam int     LEN_MAX      = 24'hff_ffff;
  localparam int     S_MIN        = -32768;
  localparam int     S_MAX        = 32767;
  // index with no register behind it; writes there must be ignored
  localparam cfg_idx_t REG_SPARE  = 3'd5;

  typedef struct packed {
    logic [15:0] sample;
    phase_t      ph;
  } shaped_t;

  // Tracks envelope state and queues the expected shaped samples
  class adsr_gain_tracker;
    logic signed [15:0] threshold;
    logic [23:0]        attack_len, decay_len, release_len;
    logic [16:0]        sustain;
    phase_t             ph;
    logic [24:0]        attack_cnt, decay_cnt, release_cnt;
    logic [16:0]        gain;
    shaped_t            shaped_q[$];
    int                 errors;

    function new();
      threshold   = '0;
      attack_len  = '0;
      decay_len   = '0;
      release_len = '0;
      sustain     = 17'(SUSTAIN_RESET);
      ph          = PH_OFF;
      attack_cnt  = '0;
      decay_cnt   = '0;
      release_cnt = '0;
      gain        = '0;
      errors      = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] data);
      case (idx)
        REG_THRESHOLD: threshold   = data[15:0];
        REG_ATTACK:    attack_len  = data[23:0];
        REG_DECAY:     decay_len   = data[23:0];
        REG_RELEASE:   release_len = data[23:0];
        REG_SUSTAIN:   sustain     = data[16:0];
        default: ;
      endcase
    endfunction

    function void accept_sample(logic signed [15:0] x, logic signed [15:0] trig,
                                logic retrig);
      bit      gate_on;
      longint  sus, env, cnt, f, prod;
      shaped_t r;
      gate_on = trig >= threshold;
      // sustain above unity is clamped
      sus = (sustain > UNITY) ? UNITY : longint'(sustain);
      env = 0;
      if (retrig) begin
        ph = PH_ATTACK;
        attack_cnt = '0;
      end
      case (ph)
        PH_ATTACK: begin
          attack_cnt = attack_cnt + 25'd1;
          if (attack_cnt > attack_len || attack_len == 0) begin
            ph = PH_DECAY;
            decay_cnt = '0;
            gain = 17'(UNITY);
            env = UNITY;
          end else begin
            cnt = longint'(attack_cnt);
            gain = 17'((cnt << FRAC_BITS) / longint'(attack_len));
            env = longint'(gain);
            if (!gate_on) begin
              ph = PH_RELEASE;
              release_cnt = '0;
            end
          end
        end
        PH_DECAY: begin
          decay_cnt = decay_cnt + 25'd1;
          if (decay_cnt > decay_len || decay_len == 0) begin
            ph = PH_SUSTAIN;
            gain = 17'(sus);
            env = sus;
          end else begin
            cnt = longint'(decay_cnt);
            gain = 17'(UNITY - ((UNITY - sus) * cnt) / longint'(decay_len));
            env = longint'(gain);
            if (!gate_on) begin
              ph = PH_RELEASE;
              release_cnt = '0;
            end
          end
        end
        PH_SUSTAIN: begin
          env = sus;
          if (!gate_on) begin
            ph = PH_RELEASE;
            release_cnt = '0;
          end
        end
        PH_RELEASE: begin
          release_cnt = release_cnt + 25'd1;
          if (release_cnt > release_len || release_len == 0) begin
            gain = '0;
            ph = PH_OFF;
            env = 0;
          end else if (gate_on) begin
            ph = PH_ATTACK;
            attack_cnt = '0;
            env = 0;
          end else begin
            // ramp down from the gain held when release began
            cnt = longint'(release_cnt);
            f = UNITY - (cnt << FRAC_BITS) / longint'(release_len);
            env = (f * longint'(gain)) >>> FRAC_BITS;
          end
        end
        default: begin
          // off, and any code outside the defined phases
          ph = PH_OFF;
          env = 0;
          if (gate_on) begin
            ph = PH_ATTACK;
            attack_cnt = '0;
          end
        end
      endcase
      // floored product: arithmetic shift rounds toward minus infinity
      prod = longint'(x) * env;
      prod = prod >>> FRAC_BITS;
      r.sample = prod[15:0];
      r.ph = ph;
      shaped_q.insert(shaped_q.size(), r);
    endfunction

    function void check_shaped(logic [15:0] sample, phase_t p);
      shaped_t exp_r;
      if (shaped_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result: sample_out %0d phase %0d",
                   $realtime, $signed(sample), p);
      end else begin
        exp_r = shaped_q[0];
        shaped_q.delete(0);
        if (sample !== exp_r.sample || p !== exp_r.ph) begin
          errors++;
          if (errors <= 10)
            $display("%0t: mismatch: sample_out exp %0d got %0d, phase exp %0d got %0d",
                     $realtime, $signed(exp_r.sample), $signed(sample), exp_r.ph, p);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  adsr_gate_in_if  #(.SAMPLE_WIDTH(16)) in_ch ();
  adsr_gate_out_if #(.SAMPLE_WIDTH(16)) out_ch ();
  adsr_gate_cfg_if                      cfg_ch ();

  adsr_envelope_gate_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  adsr_gain_tracker tracker;
  int send_gap_max;
  int recv_stall_max;
  int items_sent  = 0;
  int idle_cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Transaction monitor: feeds the tracker and checks results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        tracker.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        tracker.accept_sample(in_ch.sample_in, in_ch.trigger_level, in_ch.retrigger);
      if (out_ch.valid && out_ch.ready)
        tracker.check_shaped(out_ch.sample_out, out_ch.phase);
    end
  end

  // Watchdog: no transaction on any channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stall before each transaction
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = $urandom_range(0, recv_stall_max);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic int random_word();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int pick_length();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return LEN_MAX;
      2:       return $urandom_range(0, LEN_MAX);
      3:       return $urandom_range(13, 200);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // Trigger sample on the requested side of the threshold, with some noise
  function automatic int gate_level(int thr, bit on);
    if ($urandom_range(0, 9) == 0)
      return random_word();
    if (on)
      return thr + int'($urandom_range(0, S_MAX - thr));
    if (thr == S_MIN)
      return random_word();
    return S_MIN + int'($urandom_range(0, thr - 1 - S_MIN));
  endfunction

  task automatic send_sample(int x, int trig, bit retrig);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.sample_in     = 16'(x);
    in_ch.trigger_level = 16'(trig);
    in_ch.retrigger     = retrig;
    in_ch.valid         = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Register write; bits above the field are random
  task automatic load_reg(cfg_idx_t idx, int value);
    logic [31:0] mask;
    case (idx)
      REG_THRESHOLD:                    mask = 32'h0000_ffff;
      REG_SUSTAIN:                      mask = 32'h0001_ffff;
      REG_ATTACK, REG_DECAY, REG_RELEASE: mask = 32'h00ff_ffff;
      default:                          mask = 32'h0;
    endcase
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data  = ($urandom() & ~mask) | (32'(value) & mask);
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Stop sending and wait until every expected result is in
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.shaped_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase();
    int n, sent, thr, on_run, off_run, x;
    drain();
    send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
    recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
    // new settings for a random subset of registers
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 4))
        0:       load_reg(REG_THRESHOLD, S_MIN);
        1:       load_reg(REG_THRESHOLD, S_MAX);
        2:       load_reg(REG_THRESHOLD, int'($urandom_range(0, 4000)) - 2000);
        default: load_reg(REG_THRESHOLD, random_word());
      endcase
    end
    for (cfg_idx_t r = REG_ATTACK; r <= REG_RELEASE; r++)
      if ($urandom_range(0, 9) < 7)
        load_reg(r, pick_length());
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0:       load_reg(REG_SUSTAIN, 0);
        1:       load_reg(REG_SUSTAIN, 65536);
        2:       load_reg(REG_SUSTAIN, $urandom_range(65537, 131071));
        default: load_reg(REG_SUSTAIN, $urandom_range(0, 65536));
      endcase
    end
    cfg_done();
    thr = int'(tracker.threshold);
    // note-on / note-off bursts with random content
    n = $urandom_range(20, 50);
    sent = 0;
    while (sent < n) begin
      on_run  = $urandom_range(1, 30);
      off_run = $urandom_range(1, 12);
      for (int i = 0; i < on_run + off_run && sent < n; i++) begin
        x = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? S_MAX : S_MIN)
                                        : random_word();
        send_sample(x, gate_level(thr, i < on_run), $urandom_range(0, 15) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    tracker = new();
    in_ch.valid         = 1'b0;
    in_ch.sample_in     = '0;
    in_ch.trigger_level = '0;
    in_ch.retrigger     = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_THRESHOLD;
    cfg_ch.data         = '0;
    send_gap_max        = IDLE_MAX;
    recv_stall_max      = IDLE_MAX;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // zero-length ramps, threshold at zero, sustain one half
    load_reg(REG_THRESHOLD, 0);
    load_reg(REG_ATTACK, 0);
    load_reg(REG_DECAY, 0);
    load_reg(REG_RELEASE, 0);
    load_reg(REG_SUSTAIN, SUSTAIN_RESET);
    cfg_done();
    send_sample(S_MAX, -1, 1'b0);     // gate just below threshold: stays off
    send_sample(S_MAX, 0, 1'b0);      // gate exactly at threshold: attack
    send_sample(S_MIN, 0, 1'b0);      // zero attack: straight to decay
    send_sample(S_MAX, 5, 1'b0);      // zero decay: sustain
    send_sample(S_MIN, 0, 1'b0);
    send_sample(-1, S_MIN, 1'b0);     // gate off: release, floor of -1/2
    send_sample(100, S_MIN, 1'b0);    // zero release: off
    send_sample(1000, -5, 1'b1);      // retrigger with gate off

    // short ramps, sustain above unity, write to an unused index
    drain();
    load_reg(REG_THRESHOLD, 100);
    load_reg(REG_ATTACK, 3);
    load_reg(REG_DECAY, 2);
    load_reg(REG_RELEASE, 4);
    load_reg(REG_SUSTAIN, 70000);
    load_reg(REG_SPARE, $urandom());
    cfg_done();
    repeat (8) send_sample(20000, S_MAX, 1'b0);
    repeat (2) send_sample(-20000, 99, 1'b0);
    send_sample(12345, 100, 1'b0);    // gate back on during release
    send_sample(-12345, S_MIN, 1'b0); // gate off early in attack

    // longest ramps, zero sustain, highest threshold
    drain();
    load_reg(REG_THRESHOLD, S_MAX);
    load_reg(REG_ATTACK, LEN_MAX);
    load_reg(REG_DECAY, LEN_MAX);
    load_reg(REG_RELEASE, LEN_MAX);
    load_reg(REG_SUSTAIN, 0);
    cfg_done();
    send_sample(S_MAX, S_MAX, 1'b1);
    send_sample(S_MIN, S_MAX, 1'b0);
    send_sample(S_MAX, S_MAX, 1'b0);
    // attack shortened below the running count: ends on the next sample
    drain();
    load_reg(REG_ATTACK, 1);
    cfg_done();
    send_sample(S_MIN, S_MAX, 1'b0);

    while (items_sent < TOTAL_ITEMS)
      run_random_phase();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.shaped_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
